### hw/rtl/lirs_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Used by lirs_ctrl, lirs_datapath and linear_interp_resampler_unit; no dependencies.
package lirs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 21;

    localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_first;  // store the first sample, no output
        logic skip;        // phase already at or above 1.0: drop 1.0, store sample
        logic start;       // latch current sample and difference, begin a run
        logic issue;       // launch one interpolation, advance phase
        logic last;        // this issue closes the run
        logic clear;       // step write: clear history and phase
    } lirs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ph_ge_one;   // stored phase >= 1.0
        logic sum_ge_one;  // phase + step >= 1.0
        logic adv;         // pipeline advances this cycle
    } lirs_status_t;

endpackage

### hw/rtl/linear_interp_resampler_unit.sv
// Top level of the linear interpolation resampler.
// Depends on lirs_pkg, lirs_ctrl and lirs_datapath.
//
// Usage:
//   Input beats (s_*) carry one signed 16-bit sample each; s_tlast marks the end of
//   a pushed buffer and does not affect results. Output beats (m_*) carry
//   interpolated samples; m_tlast is set on the final output caused by one input.
//   The first sample after reset or a step write only primes the history and
//   produces no output. Each later sample produces one output per phase position
//   below 1.0 (up to MAX_OUTPUTS_PER_INPUT), phase advancing by the step ratio.
//   Throughput: a sample producing outputs keeps s_tready low until its run ends, the
//   run sequencer issuing one output per cycle while the receiver does not stall; a
//   sample producing none leaves s_tready high. Outputs pass through the multiply,
//   sum and round/saturate stages.
//   Receiver stall: the three-stage pipeline and the sequencer hold while m_tvalid
//   is high and m_tready low; s_tready stays low until the run is finished.
//   Reset (aresetn low, synchronous) sets the step to 1.0 and clears history, phase
//   and the pipeline. A cfg_we pulse loads the Q5.16 step and clears history and phase;
//   write it only while no outputs are pending.
module linear_interp_resampler_unit #(
    parameter int FRAC_BITS             = 16,
    parameter int MAX_OUTPUTS_PER_INPUT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // step_ratio write port
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,    // [20:0] step_ratio
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] sample_in
    input  logic        s_tlast,      // last_in_block, carries no effect
    // output samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [15:0] sample_out
    output logic        m_tlast       // last_of_run
);

    lirs_pkg::lirs_cmd_t    cmd;
    lirs_pkg::lirs_status_t sts;
    logic signed [15:0]     m_sample;

    // sequencer: decides priming, skipping and the length of each run
    lirs_ctrl #(
        .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg_we   (cfg_we),
        .sts      (sts),
        .cmd      (cmd)
    );

    // phase accumulator, sample history and the interpolation pipeline
    lirs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wdata (cfg_wdata),
        .s_sample  ($signed(s_tdata)),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_sample  (m_sample),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = m_sample;

endmodule

### hw/rtl/lirs_ctrl.sv
// Run controller of the linear interpolation resampler.
// Depends on lirs_pkg; drives lirs_datapath through lirs_cmd_t.
module lirs_ctrl #(
    parameter int MAX_OUTPUTS_PER_INPUT = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  cfg_we,
    input  lirs_pkg::lirs_status_t sts,
    output lirs_pkg::lirs_cmd_t    cmd
);

    localparam int CNT_W = (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_OUTPUTS_PER_INPUT - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic             have_prev_reg, have_prev_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!have_prev_reg) begin
                        cmd.load_first = 1'b1;
                        have_prev_next = 1'b1;
                    end else if (sts.ph_ge_one) begin
                        cmd.skip = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (sts.adv) begin
                    cmd.issue = 1'b1;
                    cmd.last  = sts.sum_ge_one || (cnt_reg == CNT_CAP);
                    cnt_next  = cnt_reg + 1'b1;
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // a step write restarts the stream
        if (cfg_we) begin
            cmd.clear      = 1'b1;
            have_prev_next = 1'b0;
            state_next     = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            cnt_reg       <= cnt_next;
        end
    end

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && sts.adv && !cfg_we && (sts.sum_ge_one || cnt_reg == CNT_CAP))
        |=> state_reg == ST_IDLE)
        else $error("run did not end at phase overflow or output cap");

    a_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && have_prev_reg && !sts.ph_ge_one && !cfg_we)
        |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("run did not start on accepted sample");

    a_run_has_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> have_prev_reg)
        else $error("run without a previous sample");

endmodule

### hw/rtl/lirs_datapath.sv
// Datapath of the linear interpolation resampler: phase, history, multiply-round pipeline.
// Depends on lirs_pkg; controlled by lirs_ctrl.
module lirs_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lirs_pkg::lirs_cmd_t                  cmd,
    output lirs_pkg::lirs_status_t               sts,
    input  logic [lirs_pkg::STEP_W-1:0]          cfg_wdata,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                 m_tlast
);

    localparam int SW    = lirs_pkg::SAMPLE_W;
    localparam int STW   = lirs_pkg::STEP_W;
    localparam int ACC_W = FRAC_BITS + SW + 2;
    localparam int PH_MAXW = (FRAC_BITS + 5 > STW) ? FRAC_BITS + 5 : STW;
    localparam int PH_W  = PH_MAXW + 1;
    localparam logic [PH_W-1:0]  PH_ONE   = PH_W'(1) << FRAC_BITS;
    localparam logic [STW-1:0]   STEP_RST = (FRAC_BITS < STW) ? (STW'(1) << FRAC_BITS) : '0;
    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic [STW-1:0]          step_reg;
    logic [PH_W-1:0]         ph_reg;
    logic signed [SW-1:0]    prev_reg;
    logic signed [SW-1:0]    cur_reg;
    logic signed [SW:0]      diff_reg;

    logic [PH_W-1:0]         ph_sum;
    logic [PH_W-1:0]         ph_sum_dec;
    logic [PH_W-1:0]         ph_dec;
    logic                    adv;

    // pipeline: S1 product, S2 sum, S3 rounded output
    logic                    v1_reg, v2_reg;
    logic                    last1_reg, last2_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [SW-1:0]    base_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] base_ext;
    logic signed [ACC_W-1:0] rsum;
    logic signed [ACC_W-FRAC_BITS-1:0] rnd;
    logic signed [SW-1:0]    sat;

    assign ph_sum     = ph_reg + PH_W'(step_reg);
    assign ph_sum_dec = ph_sum - PH_ONE;
    assign ph_dec     = ph_reg - PH_ONE;
    assign adv        = !m_tvalid || m_tready;

    assign sts.ph_ge_one  = (ph_reg >= PH_ONE);
    assign sts.sum_ge_one = (ph_sum >= PH_ONE);
    assign sts.adv        = adv;

    // step, phase and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RST;
            ph_reg   <= '0;
            prev_reg <= '0;
        end else if (cmd.clear) begin
            step_reg <= cfg_wdata;
            ph_reg   <= '0;
            prev_reg <= '0;
        end else begin
            if (cmd.load_first) begin
                prev_reg <= s_sample;
            end
            if (cmd.skip) begin
                prev_reg <= s_sample;
                ph_reg   <= PH_W'(ph_dec[FRAC_BITS+4:0]);
            end
            if (cmd.issue) begin
                if (cmd.last) begin
                    prev_reg <= cur_reg;
                    ph_reg   <= sts.sum_ge_one ? PH_W'(ph_sum_dec[FRAC_BITS+4:0]) : '0;
                end else begin
                    ph_reg <= ph_sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_reg  <= s_sample;
            diff_reg <= (SW+1)'(s_sample) - (SW+1)'(prev_reg);
        end
    end

    // acc = prev * 2^F + (cur - prev) * phase
    assign base_ext = {{2{base_reg[SW-1]}}, base_reg, {FRAC_BITS{1'b0}}};
    // round half away from zero: bias negatives down by one before the floor shift
    assign rsum = acc_reg + $signed(ACC_HALF) - $signed(ACC_W'(acc_reg[ACC_W-1]));
    assign rnd  = rsum[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (rnd > lirs_pkg::SAMPLE_MAX) begin
            sat = SW'(lirs_pkg::SAMPLE_MAX);
        end else if (rnd < lirs_pkg::SAMPLE_MIN) begin
            sat = SW'(lirs_pkg::SAMPLE_MIN);
        end else begin
            sat = rnd[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else if (adv) begin
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            m_tvalid <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg  <= ACC_W'(diff_reg * $signed({1'b0, ph_reg[FRAC_BITS-1:0]}));
            base_reg  <= prev_reg;
            last1_reg <= cmd.last;
            acc_reg   <= base_ext + prod_reg;
            last2_reg <= last1_reg;
            m_sample  <= sat;
            m_tlast   <= last2_reg;
        end
    end

    a_no_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (rnd <= lirs_pkg::SAMPLE_MAX && rnd >= lirs_pkg::SAMPLE_MIN))
        else $error("interpolated value outside sample range");

    a_phase_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && cmd.last && !cmd.clear) |=> ph_reg[PH_W-1:FRAC_BITS+5] == '0)
        else $error("stored phase exceeds its width after a run");

endmodule
